FILE: hw/rtl/dbsk_pkg.sv
`default_nettype none

package dbsk_pkg;

  localparam int KEY_W          = 64;
  localparam int ACTION_W       = 2;
  localparam int STATUS_W       = 2;
  localparam int ENTRY_W        = 13;
  localparam int BANK_DEPTH_DEF = 4096;

  // Request action codes.
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COMMIT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNSORTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  // Decoded operation handed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_APPEND,
    OP_COMMIT,
    OP_LOOKUP,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dbsk_if.sv
`default_nettype none

interface dbsk_req_if;
  logic                          valid;
  logic                          ready;
  logic [dbsk_pkg::ACTION_W-1:0] action;
  logic [dbsk_pkg::KEY_W-1:0]    key_value;

  modport source (output valid, output action, output key_value, input ready);
  modport sink (input valid, input action, input key_value, output ready);
endinterface

interface dbsk_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [dbsk_pkg::STATUS_W-1:0] status;
  logic [dbsk_pkg::ENTRY_W-1:0]  entry_count;

  modport source (output valid, output found, output status, output entry_count,
                  input ready);
  modport sink (input valid, input found, input status, input entry_count,
                output ready);
endinterface

interface dbsk_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dbsk_pkg::ENTRY_W-1:0] min_entries;

  modport source (output valid, output min_entries, input ready);
  modport sink (input valid, input min_entries, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dbsk_front.sv
`default_nettype none

module dbsk_front (
  input  wire logic     clk,
  input  wire logic     rst,
  dbsk_req_if.sink      req,
  output dbsk_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  wire logic     cmd_pop
);

  dbsk_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           push;
  dbsk_pkg::op_t  op_dec;

  // Classify the action; unused codes become a no-op.
  always_comb begin
    case (req.action)
      dbsk_pkg::ACT_APPEND: op_dec = dbsk_pkg::OP_APPEND;
      dbsk_pkg::ACT_COMMIT: op_dec = dbsk_pkg::OP_COMMIT;
      dbsk_pkg::ACT_LOOKUP: op_dec = dbsk_pkg::OP_LOOKUP;
      default:              op_dec = dbsk_pkg::OP_NOP;
    endcase
  end

  assign req.ready = (cnt != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op_dec, key: req.key_value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      case ({push, cmd_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dbsk_back.sv
`default_nettype none

module dbsk_back #(
  parameter int BANK_DEPTH = dbsk_pkg::BANK_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dbsk_pkg::cmd_t cmd,
  input  wire logic           cmd_valid,
  output logic                cmd_pop,
  dbsk_cfg_if.sink            cfg,
  dbsk_rsp_if.source          rsp
);

  localparam int IDX_W     = $clog2(BANK_DEPTH);
  localparam int CNT_W     = $clog2(BANK_DEPTH + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int MEM_DEPTH = 2 * (2 ** IDX_W);
  localparam int KW        = dbsk_pkg::KEY_W;
  localparam int EW        = dbsk_pkg::ENTRY_W;
  localparam int SW        = dbsk_pkg::STATUS_W;
  localparam int CMP_W     = (CNT_W > EW) ? CNT_W : EW;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  // Key memory: both banks, bank select on the top address bit.
  logic [KW-1:0]     mem [MEM_DEPTH];
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [KW-1:0]     rdata;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;

  state_t            state, state_next;
  logic              active_bank, active_bank_next;
  logic [CNT_W-1:0]  active_count, active_count_next;
  logic [CNT_W-1:0]  staged_count, staged_count_next;
  logic [KW-1:0]     last_key, last_key_next;
  logic              order_broken, order_broken_next;
  logic              overflow, overflow_next;
  logic [EW-1:0]     min_entries;
  logic [KW-1:0]     key_q, key_q_next;
  logic [CNT_W-1:0]  lo, lo_next;
  logic [CNT_W-1:0]  hi, hi_next;
  logic [IDX_W-1:0]  mid_q, mid_q_next;
  logic              rsp_valid, rsp_valid_next;
  logic              rsp_found, rsp_found_next;
  logic [SW-1:0]     rsp_status, rsp_status_next;
  logic [EW-1:0]     rsp_count, rsp_count_next;

  logic              out_free;
  logic              key_lt;
  logic [CNT_W-1:0]  lo_step, hi_step;
  logic [CNT_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid_step;
  logic [SW-1:0]     commit_status;

  assign cfg.ready       = 1'b1;
  assign rsp.valid       = rsp_valid;
  assign rsp.found       = rsp_found;
  assign rsp.status      = rsp_status;
  assign rsp.entry_count = rsp_count;

  assign out_free = !rsp_valid || rsp.ready;

  // One search step on the entry read last cycle.
  assign key_lt   = rdata < key_q;
  assign lo_step  = key_lt ? (CNT_W'(mid_q) + CNT_W'(1)) : lo;
  assign hi_step  = key_lt ? hi : CNT_W'(mid_q);
  assign mid_sum  = {1'b0, lo_step} + {1'b0, hi_step};
  assign mid_step = mid_sum[IDX_W:1];

  always_comb begin
    if (CMP_W'(staged_count) < CMP_W'(min_entries)) commit_status = dbsk_pkg::ST_TOO_FEW;
    else if (overflow)     commit_status = dbsk_pkg::ST_FULL;
    else if (order_broken) commit_status = dbsk_pkg::ST_UNSORTED;
    else                   commit_status = dbsk_pkg::ST_OK;
  end

  always_comb begin
    state_next        = state;
    active_bank_next  = active_bank;
    active_count_next = active_count;
    staged_count_next = staged_count;
    last_key_next     = last_key;
    order_broken_next = order_broken;
    overflow_next     = overflow;
    key_q_next        = key_q;
    lo_next           = lo;
    hi_next           = hi;
    mid_q_next        = mid_q;
    rsp_valid_next    = rsp_valid && !rsp.ready;
    rsp_found_next    = rsp_found;
    rsp_status_next   = rsp_status;
    rsp_count_next    = rsp_count;
    cmd_pop           = 1'b0;
    rd_en             = 1'b0;
    rd_addr           = '0;
    wr_en             = 1'b0;
    wr_addr           = {~active_bank, staged_count[IDX_W-1:0]};

    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop         = 1'b1;
          rsp_found_next  = 1'b0;
          rsp_status_next = dbsk_pkg::ST_OK;
          rsp_count_next  = EW'(active_count);
          case (cmd.op)
            dbsk_pkg::OP_APPEND: begin
              rsp_valid_next = 1'b1;
              if (staged_count == CNT_W'(BANK_DEPTH)) begin
                overflow_next = 1'b1;
              end else begin
                if (staged_count != '0 && cmd.key <= last_key) order_broken_next = 1'b1;
                wr_en             = 1'b1;
                staged_count_next = staged_count + CNT_W'(1);
                last_key_next     = cmd.key;
              end
              if (overflow_next)          rsp_status_next = dbsk_pkg::ST_FULL;
              else if (order_broken_next) rsp_status_next = dbsk_pkg::ST_UNSORTED;
              else                        rsp_status_next = dbsk_pkg::ST_OK;
            end
            dbsk_pkg::OP_COMMIT: begin
              rsp_valid_next  = 1'b1;
              rsp_status_next = commit_status;
              if (commit_status == dbsk_pkg::ST_OK) begin
                active_bank_next  = ~active_bank;
                active_count_next = staged_count;
                rsp_count_next    = EW'(staged_count);
              end
              staged_count_next = '0;
              last_key_next     = '0;
              order_broken_next = 1'b0;
              overflow_next     = 1'b0;
            end
            dbsk_pkg::OP_LOOKUP: begin
              key_q_next = cmd.key;
              if (active_count == '0) begin
                rsp_valid_next = 1'b1;
              end else begin
                lo_next    = '0;
                hi_next    = active_count;
                mid_q_next = IDX_W'(active_count >> 1);
                rd_en      = 1'b1;
                rd_addr    = {active_bank, IDX_W'(active_count >> 1)};
                state_next = S_SEARCH;
              end
            end
            default: begin
              rsp_valid_next = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (rdata == key_q) begin
          rsp_valid_next = 1'b1;
          rsp_found_next = 1'b1;
          state_next     = S_IDLE;
        end else if (lo_step >= hi_step) begin
          rsp_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          lo_next    = lo_step;
          hi_next    = hi_step;
          mid_q_next = mid_step;
          rd_en      = 1'b1;
          rd_addr    = {active_bank, mid_step};
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= cmd.key;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_bank  <= 1'b0;
      active_count <= '0;
      staged_count <= '0;
      last_key     <= '0;
      order_broken <= 1'b0;
      overflow     <= 1'b0;
      min_entries  <= EW'(1);
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      active_bank  <= active_bank_next;
      active_count <= active_count_next;
      staged_count <= staged_count_next;
      last_key     <= last_key_next;
      order_broken <= order_broken_next;
      overflow     <= overflow_next;
      rsp_valid    <= rsp_valid_next;
      if (cfg.valid) min_entries <= cfg.min_entries;
    end
    key_q      <= key_q_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid_q      <= mid_q_next;
    rsp_found  <= rsp_found_next;
    rsp_status <= rsp_status_next;
    rsp_count  <= rsp_count_next;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dual_bank_sorted_key_set_unit.sv
`default_nettype none

// Dual-bank sorted key set.
// req carries one request per handshake: action (append, commit, lookup) and
// key_value. rsp returns one response per request, in order: found, status
// and the active entry count after the request. cfg writes min_entries, the
// smallest staged count a commit accepts; it is always ready and must only be
// written while no request is in flight.
// An append, commit or unused action is held in the front queue, then answered
// from the executor's response register.
// A lookup runs a binary search over the active keys that issues one key-memory
// read per cycle from its single read port, and the compare of each read picks
// the next address.
// Throughput: appends and commits retire one per cycle while rsp takes every
// response; the executor holds a lookup until its search ends.
// Reset clears both banks to empty (active count zero, staging empty) and
// sets min_entries to 1; no clearing pass runs, the key memory is never read
// beyond what was written. When rsp stalls, the response holds in its output
// register, the executor stops, and the two-entry front queue fills before
// req drops ready.
module dual_bank_sorted_key_set_unit #(
  parameter int BANK_DEPTH = dbsk_pkg::BANK_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dbsk_req_if.sink   req,
  dbsk_rsp_if.source rsp,
  dbsk_cfg_if.sink   cfg
);

  // Decoded request handed from the front queue to the executor.
  dbsk_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  // Front end: classify each request and hold it in a short queue.
  dbsk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  // Back end: staging, commit, binary search and the response register.
  dbsk_back #(
    .BANK_DEPTH (BANK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .rsp       (rsp)
  );

  // Drop nothing: the executor only takes a request the queue holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("executor took a request from an empty queue");

  // Only a lookup can report a hit, and a lookup never reports an error.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == dbsk_pkg::ST_OK)
    else $error("hit reported with a nonzero status");

  // Appends and commits answer in the cycle after they are taken.
  a_short_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_pop && cmd.op != dbsk_pkg::OP_LOOKUP |=> rsp.valid)
    else $error("non-lookup request did not answer in one cycle");

endmodule

`default_nettype wire
